### rtl/idq_pkg.sv
package idq_pkg;

	// widths of the fixed payload fields
	localparam int unsigned DATA_W = 32;
	localparam int unsigned POS_W = 4;
	localparam int unsigned COUNT_W = 5;
	localparam int unsigned KIND_W = 3;

	// default ring depth
	localparam int unsigned QUEUE_DEPTH_DEF = 16;

	// operation codes
	typedef enum logic [KIND_W-1:0] {
		KIND_ADD_FRONT = 3'd0,
		KIND_ADD_BACK  = 3'd1,
		KIND_REM_FRONT = 3'd2,
		KIND_REM_BACK  = 3'd3,
		KIND_READ      = 3'd4
	} kind_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_RANGE = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	// command payload
	typedef struct packed {
		logic [KIND_W-1:0]        kind;
		logic signed [DATA_W-1:0] value;
		logic [POS_W-1:0]         position;
	} cmd_t;

	// result payload
	typedef struct packed {
		logic signed [DATA_W-1:0] read_data;
		logic [1:0]               status;
		logic [COUNT_W-1:0]       entry_count;
	} res_t;

	// item waiting for the ram read data
	typedef struct packed {
		logic               valid;
		logic               rd_ok;
		status_t            status;
		logic [COUNT_W-1:0] count;
	} stage_t;

endpackage

### rtl/idq_ram.sv
module idq_ram import idq_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF,
	localparam int unsigned IDX_W = $clog2(QUEUE_DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic              re,
	input  logic [IDX_W-1:0]  addr,
	input  logic [DATA_W-1:0] wdata,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [QUEUE_DEPTH];

	// single port, registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

### rtl/idq_ctrl.sv
module idq_ctrl import idq_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF,
	localparam int unsigned IDX_W = $clog2(QUEUE_DEPTH),
	localparam int unsigned OCC_W = $clog2(QUEUE_DEPTH + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_ready,
	input  cmd_t              cmd,
	input  logic              adv,
	output logic              mem_we,
	output logic              mem_re,
	output logic [IDX_W-1:0]  mem_addr,
	output logic [DATA_W-1:0] mem_wdata,
	output stage_t            stage_s1
);

	localparam int unsigned CMP_W = (OCC_W > POS_W) ? OCC_W : POS_W;
	localparam int unsigned EXT_W = (OCC_W > COUNT_W) ? OCC_W : COUNT_W;

	logic [IDX_W-1:0] front_q, front_d;
	logic [OCC_W-1:0] occ_q, occ_d;
	logic             accept;
	logic             full, empty;
	logic [CMP_W-1:0] pos_ext, occ_ext;
	logic [IDX_W-1:0] offset, front_dec, front_inc, ring_idx;
	logic [IDX_W:0]   ring_sum;
	logic [EXT_W-1:0] count_ext;
	logic             we_d, re_d, rd_ok_d;
	status_t          status_d;
	logic               valid_s1;
	logic               rd_ok_s1;
	status_t            status_s1;
	logic [COUNT_W-1:0] count_s1;

	assign cmd_ready = !valid_s1 || adv;
	assign accept = cmd_valid && cmd_ready;

	// occupancy flags and widened operands
	assign full = (occ_q == OCC_W'(QUEUE_DEPTH));
	assign empty = (occ_q == '0);
	assign pos_ext = CMP_W'(cmd.position);
	assign occ_ext = CMP_W'(occ_q);

	// ring arithmetic around the front entry
	assign front_dec = (front_q == '0) ? IDX_W'(QUEUE_DEPTH - 1) : front_q - IDX_W'(1);
	assign front_inc = (front_q == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : front_q + IDX_W'(1);
	assign offset = (cmd.kind == KIND_ADD_BACK) ? occ_q[IDX_W-1:0] : pos_ext[IDX_W-1:0];
	assign ring_sum = {1'b0, front_q} + {1'b0, offset};
	assign ring_idx = (ring_sum >= (IDX_W+1)'(QUEUE_DEPTH))
		? IDX_W'(ring_sum - (IDX_W+1)'(QUEUE_DEPTH)) : ring_sum[IDX_W-1:0];

	// operation decode
	always_comb begin
		we_d = 1'b0;
		re_d = 1'b0;
		rd_ok_d = 1'b0;
		mem_addr = ring_idx;
		front_d = front_q;
		occ_d = occ_q;
		status_d = ST_OK;
		unique case (cmd.kind)
			KIND_ADD_FRONT: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					we_d = 1'b1;
					mem_addr = front_dec;
					front_d = front_dec;
					occ_d = occ_q + OCC_W'(1);
				end
			end
			KIND_ADD_BACK: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					we_d = 1'b1;
					occ_d = occ_q + OCC_W'(1);
				end
			end
			KIND_REM_FRONT: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else begin
					front_d = front_inc;
					occ_d = occ_q - OCC_W'(1);
				end
			end
			KIND_REM_BACK: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else begin
					occ_d = occ_q - OCC_W'(1);
				end
			end
			KIND_READ: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else if (pos_ext >= occ_ext) begin
					status_d = ST_RANGE;
				end else begin
					re_d = 1'b1;
					rd_ok_d = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign mem_we = accept && we_d;
	assign mem_re = accept && re_d;
	assign mem_wdata = cmd.value;
	assign count_ext = EXT_W'(occ_d);

	// ring pointer and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			occ_q <= '0;
		end else if (accept) begin
			front_q <= front_d;
			occ_q <= occ_d;
		end
	end

	// item waiting for the ram read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_ok_s1 <= rd_ok_d;
			status_s1 <= status_d;
			count_s1 <= count_ext[COUNT_W-1:0];
		end
	end

	assign stage_s1 = '{valid: valid_s1, rd_ok: rd_ok_s1, status: status_s1,
		count: count_s1};

`ifndef SYNTHESIS
	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OCC_W'(QUEUE_DEPTH))
		else $error("occupancy beyond depth");

	a_one_access: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_we && mem_re))
		else $error("ram written and read by one item");

	a_add_grows: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |=> occ_q == $past(occ_q) + OCC_W'(1))
		else $error("stored add did not raise the count");

	a_read_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		mem_re |-> (pos_ext < occ_ext) && !empty)
		else $error("ram read outside the occupied range");

	a_full_flag: assert property (@(posedge clk) disable iff (!arst_n)
		accept && status_d == ST_FULL |-> full && !we_d)
		else $error("full status without a full ring");
`endif

endmodule

### rtl/indexed_double_ended_queue_core.sv
// Bounded double-ended queue of signed 32-bit words held in a single-port ring ram of
// QUEUE_DEPTH entries with a front pointer and an entry count. Each command transfer adds at
// the front or back, removes at the front or back, or reads the entry at a position counted
// from the front, and yields exactly one result transfer with the read word, a status (ok,
// empty, out of range, full) and the count after the command. One command is taken per clock
// cycle while results are taken as they come; a stalled result holds the output register and
// the ram stage, and commands are refused once both are occupied. A result passes from the
// ram stage, where the read data is registered, into the output register. Every command makes
// at most one ram access, and a write lands before the next command's read, so back-to-back
// commands need no forwarding.
// Adds to a full queue are dropped; the ram has no reset and needs no clearing.
module indexed_double_ended_queue_core import idq_pkg::*; #(
	parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	output logic cmd_ready,
	input  cmd_t cmd,
	output logic res_valid,
	input  logic res_ready,
	output res_t res
);

	localparam int unsigned IDX_W = $clog2(QUEUE_DEPTH);

	logic              adv;
	logic              mem_we, mem_re;
	logic [IDX_W-1:0]  mem_addr;
	logic [DATA_W-1:0] mem_wdata, mem_rdata;
	stage_t            stage_s1;
	logic              res_valid_q;
	res_t              res_q;

	idq_ctrl #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd      (cmd),
		.adv      (adv),
		.mem_we   (mem_we),
		.mem_re   (mem_re),
		.mem_addr (mem_addr),
		.mem_wdata(mem_wdata),
		.stage_s1 (stage_s1)
	);

	idq_ram #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (mem_we),
		.re   (mem_re),
		.addr (mem_addr),
		.wdata(mem_wdata),
		.rdata(mem_rdata)
	);

	// output register frees whenever it is empty or its transfer completes
	assign adv = !res_valid_q || res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= stage_s1.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && stage_s1.valid) begin
			res_q.read_data <= stage_s1.rd_ok ? $signed(mem_rdata) : '0;
			res_q.status <= stage_s1.status;
			res_q.entry_count <= stage_s1.count;
		end
	end

	assign res_valid = res_valid_q;
	assign res = res_q;

endmodule
